[hdl/mur2_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mur2_pkg : shared constants for the byte-serial MurmurHash2 block
// Widths of the stream fields, the mixing constants and the seed reset value.
// ----------------------------------------------------------------------------
package mur2_pkg;

  // Stream field widths
  localparam int KEY_BYTE_W   = 8;
  localparam int KEY_LENGTH_W = 16;
  localparam int HASH_W       = 32;
  localparam int WORD_BYTES_W = 24;

  // Default for the number of key-length bits taken into the seed term
  localparam int KEY_LEN_BITS_DEF = 16;

  // MurmurHash2 mixing constants
  localparam logic [HASH_W-1:0] MUR_M      = 32'h5bd1_e995;
  localparam int                MUR_R      = 24;
  localparam int                FIN_A      = 13;
  localparam int                FIN_B      = 15;
  localparam logic [HASH_W-1:0] SEED_RESET = 32'd97;

endpackage

[hdl/mur2_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mur2_if : stream channels of the MurmurHash2 block
// Key byte channel into the block and hash result channel out of it.
// ----------------------------------------------------------------------------

// Key byte channel
interface mur2_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [mur2_pkg::KEY_BYTE_W-1:0]      key_byte;
  logic [mur2_pkg::KEY_LENGTH_W-1:0]    key_length;
  logic                                 first_byte;
  logic                                 last_byte;

  modport source (output valid, key_byte, key_length, first_byte, last_byte,
                  input  ready);
  modport sink   (input  valid, key_byte, key_length, first_byte, last_byte,
                  output ready);
endinterface

// Hash result channel
interface mur2_out_if;
  logic                          valid;
  logic                          ready;
  logic [mur2_pkg::HASH_W-1:0]   digest;

  modport source (output valid, digest, input ready);
  modport sink   (input  valid, digest, output ready);
endinterface

[hdl/mur2_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mur2_mul : shared multiply-by-M unit
// Registered low 32 bits of op * M; the product updates only when enabled.
// ----------------------------------------------------------------------------
module mur2_mul (
  input  logic                        clk,
  input  logic                        en,
  input  logic [mur2_pkg::HASH_W-1:0] op,
  output logic [mur2_pkg::HASH_W-1:0] prod
);
  import mur2_pkg::*;

  logic [HASH_W-1:0]   prod_r;
  logic [HASH_W-1:0]   prod_nxt;

  // modulo 2^32 product
  always_comb begin
    prod_nxt = en ? (op * MUR_M) : prod_r;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

[hdl/murmur2_byte_hasher_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur2_byte_hasher_top : byte-serial 32-bit MurmurHash2
// Packs key bytes into words and mixes them through one shared multiplier.
// ----------------------------------------------------------------------------
// Usage
//   in_if  : one key byte per beat, with key_length, first_byte, last_byte.
//            first_byte restarts the hash as seed ^ length; last_byte closes
//            the key and yields one hash beat on out_if.
//   cfg_we : writes cfg_wdata into the seed; write only while idle.
// Sequencing (one multiplier by M, registered, stepped by a small FSM)
//   - a byte that does not complete a word is packed into the word in idle
//   - a byte that completes a word: three products in turn, through K1, K2, K3
//   - the last byte adds the tail product and the final product; the hash
//     is then registered in the output slot.
//   No new byte is taken while a word is mixed or a hash is finished.
// Stalls
//   The hash sits in an output register; bytes of the next key are still
//   taken while it waits. Only the next finished hash waits for the slot.
// Reset
//   rst_n low clears the hash state, the output valid, and sets seed to 97.
// ----------------------------------------------------------------------------
module murmur2_byte_hasher_top #(
  parameter int KEY_LEN_BITS = mur2_pkg::KEY_LEN_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mur2_in_if.sink                     in_if,
  mur2_out_if.source                  out_if,
  input  logic                        cfg_we,
  input  logic [mur2_pkg::HASH_W-1:0] cfg_wdata
);
  import mur2_pkg::*;

  localparam logic [HASH_W:0]   LEN_MASK_W = ({{HASH_W{1'b0}}, 1'b1} << KEY_LEN_BITS)
                                             - {{HASH_W{1'b0}}, 1'b1};
  localparam logic [HASH_W-1:0] LEN_MASK   = LEN_MASK_W[HASH_W-1:0];

  // sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_K1    = 3'd1;
  localparam logic [2:0] ST_K2    = 3'd2;
  localparam logic [2:0] ST_K3    = 3'd3;
  localparam logic [2:0] ST_TAIL  = 3'd4;
  localparam logic [2:0] ST_TAIL2 = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic [HASH_W-1:0]       h_r, h_nxt;
  logic [HASH_W-1:0]       k_r, k_nxt;
  logic [WORD_BYTES_W-1:0] word_r, word_nxt;
  logic [1:0]              phase_r, phase_nxt;
  logic                    last_r, last_nxt;
  logic [HASH_W-1:0]       seed_r, seed_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [HASH_W-1:0]       out_hash_r, out_hash_nxt;

  logic                    accept;
  logic                    slot_free;
  logic [HASH_W-1:0]       len_ext;
  logic [HASH_W-1:0]       h0;
  logic [WORD_BYTES_W-1:0] w0;
  logic [WORD_BYTES_W-1:0] w1;
  logic [1:0]              p0;
  logic [HASH_W-1:0]       mix_t;
  logic [HASH_W-1:0]       h_word;
  logic [HASH_W-1:0]       mul_op;
  logic                    mul_en;
  logic [HASH_W-1:0]       mul_prod;

  // shared multiplier
  mur2_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op   (mul_op),
    .prod (mul_prod)
  );

  assign in_if.ready   = (state_r == ST_IDLE);
  assign accept        = in_if.valid && in_if.ready;
  assign slot_free     = !out_valid_r || out_if.ready;
  assign out_if.valid  = out_valid_r;
  assign out_if.digest = out_hash_r;

  // start-of-key selection and byte packing
  always_comb begin
    len_ext = {{(HASH_W-KEY_LENGTH_W){1'b0}}, in_if.key_length} & LEN_MASK;
    h0      = in_if.first_byte ? (seed_r ^ len_ext) : h_r;
    w0      = in_if.first_byte ? '0 : word_r;
    p0      = in_if.first_byte ? 2'd0 : phase_r;
    w1      = w0 | ({{(WORD_BYTES_W-KEY_BYTE_W){1'b0}}, in_if.key_byte} << {p0, 3'b000});
    mix_t   = mul_prod ^ (mul_prod >> MUR_R);
    h_word  = mul_prod ^ k_r;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    k_nxt         = k_r;
    word_nxt      = word_r;
    phase_nxt     = phase_r;
    last_nxt      = last_r;
    seed_nxt      = cfg_we ? cfg_wdata : seed_r;
    out_valid_nxt = (out_valid_r && out_if.ready) ? 1'b0 : out_valid_r;
    out_hash_nxt  = out_hash_r;
    mul_en        = 1'b0;
    mul_op        = h_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          h_nxt    = h0;
          last_nxt = in_if.last_byte;
          if (p0 == 2'd3) begin
            // word complete: k * M first
            mul_en    = 1'b1;
            mul_op    = {in_if.key_byte, w0};
            word_nxt  = '0;
            phase_nxt = 2'd0;
            state_nxt = ST_K1;
          end else begin
            word_nxt  = w1;
            phase_nxt = p0 + 2'd1;
            if (in_if.last_byte) begin
              state_nxt = ST_TAIL;
            end
          end
        end
      end
      ST_K1: begin
        // k ^= k >> 24, then k * M
        mul_en    = 1'b1;
        mul_op    = mix_t;
        state_nxt = ST_K2;
      end
      ST_K2: begin
        k_nxt     = mul_prod;
        mul_en    = 1'b1;
        mul_op    = h_r;
        state_nxt = ST_K3;
      end
      ST_K3: begin
        // fold the word into h
        h_nxt = h_word;
        if (last_r) begin
          mul_en    = 1'b1;
          mul_op    = h_word ^ (h_word >> FIN_A);
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TAIL: begin
        mul_en    = 1'b1;
        mul_op    = h_r ^ {{(HASH_W-WORD_BYTES_W){1'b0}}, word_r};
        state_nxt = ST_TAIL2;
      end
      ST_TAIL2: begin
        mul_en    = 1'b1;
        mul_op    = mul_prod ^ (mul_prod >> FIN_A);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold the product until the output slot is free
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = mul_prod ^ (mul_prod >> FIN_B);
          h_nxt         = '0;
          word_nxt      = '0;
          phase_nxt     = 2'd0;
          last_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and hash state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      h_r         <= '0;
      word_r      <= '0;
      phase_r     <= 2'd0;
      last_r      <= 1'b0;
      seed_r      <= SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h_r         <= h_nxt;
      word_r      <= word_nxt;
      phase_r     <= phase_nxt;
      last_r      <= last_nxt;
      seed_r      <= seed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    out_hash_r <= out_hash_nxt;
  end

endmodule

[tb/tb_murmur2_byte_hasher_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_murmur2_byte_hasher_top : self-checking bench for the MurmurHash2 block
// Feeds keys byte by byte under random back-pressure and seed changes. Each
// accepted byte runs through an in-bench model of the hash. Every hash beat
// is then checked against the oldest hash still due.
// ----------------------------------------------------------------------------
module tb_murmur2_byte_hasher_top;
  import mur2_pkg::*;

  localparam int IDLE_PCT      = 16;   // idle chance per beat, each side
  localparam int HOLD_CYCLES   = 300;  // long receiver hold-off
  localparam int SETTLE_CYCLES = 12;   // block latency margin before a write
  localparam int QUIET_LIMIT   = 4000; // cycles with no beat before giving up
  localparam int PHASE_BEATS   = 100;

  // Running model of the hash, and the hashes it says are due
  class murmur_scoreboard;
    logic [HASH_W-1:0]       seed;
    logic [HASH_W-1:0]       acc;
    logic [WORD_BYTES_W-1:0] tail_word;
    logic [1:0]              tail_count;
    logic [HASH_W-1:0]       hashes_due[$];
    int                      mismatches;

    function new();
      seed       = SEED_RESET;
      acc        = '0;
      tail_word  = '0;
      tail_count = '0;
      mismatches = 0;
    endfunction

    function void set_seed(logic [HASH_W-1:0] s);
      seed = s;
    endfunction

    function logic [HASH_W-1:0] mix_word(logic [HASH_W-1:0] k);
      k = k * MUR_M;
      k = k ^ (k >> MUR_R);
      k = k * MUR_M;
      return k;
    endfunction

    // one accepted key byte
    function void note_byte(logic [KEY_BYTE_W-1:0] b, logic [KEY_LENGTH_W-1:0] len,
                            logic first, logic last);
      logic [HASH_W-1:0] h;
      if (first) begin
        acc        = seed ^ HASH_W'(len);
        tail_word  = '0;
        tail_count = '0;
      end
      // pack little-endian; the fourth byte closes a word
      case (tail_count)
        2'd0: tail_word[7:0]   = b;
        2'd1: tail_word[15:8]  = b;
        2'd2: tail_word[23:16] = b;
        default: begin
          acc        = (acc * MUR_M) ^ mix_word({b, tail_word});
          tail_word  = '0;
        end
      endcase
      tail_count = tail_count + 2'd1;
      if (last) begin
        h = acc;
        if (tail_count != 2'd0) begin
          h = h ^ HASH_W'(tail_word);
          h = h * MUR_M;
        end
        h = h ^ (h >> FIN_A);
        h = h * MUR_M;
        h = h ^ (h >> FIN_B);
        hashes_due = {hashes_due, h};
        acc        = '0;
        tail_word  = '0;
        tail_count = '0;
      end
    endfunction

    // one accepted hash beat
    function void check_hash(logic [HASH_W-1:0] got);
      logic [HASH_W-1:0] want;
      if (hashes_due.size() == 0) begin
        $display("%0t: unexpected hash beat, expected none, got %08h", $time, got);
        mismatches++;
      end else begin
        want = hashes_due.pop_front();
        if (got !== want) begin
          $display("%0t: digest mismatch, expected %08h, got %08h",
                   $time, want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [HASH_W-1:0] cfg_wdata;

  mur2_in_if  in_ch ();
  mur2_out_if out_ch ();

  murmur_scoreboard sb = new();

  bit calm;        // no idling on either side
  bit hold_req;    // ask the receiver for a long hold-off
  int beats_sent;
  int quiet_cycles;

  murmur2_byte_hasher_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random ready, calm stretches and one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Monitor both channels; watchdog on beats
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_hash(out_ch.digest);
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_byte(in_ch.key_byte, in_ch.key_length, in_ch.first_byte, in_ch.last_byte);
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_murmur2_byte_hasher_top NOT OK");
        $finish;
      end
    end
  end

  // Offer one byte and wait for its beat; valid stays high afterwards
  task automatic send_beat(input logic [KEY_BYTE_W-1:0] b,
                           input logic [KEY_LENGTH_W-1:0] len,
                           input logic first, input logic last);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.key_byte   <= b;
    in_ch.key_length <= len;
    in_ch.first_byte <= first;
    in_ch.last_byte  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  // A run of n bytes; fill < 0 gives random bytes, else a constant byte
  task automatic send_key(input int n, input logic [KEY_LENGTH_W-1:0] len,
                          input bit mark_first, input bit mark_last, input int fill);
    logic [KEY_BYTE_W-1:0]   b;
    logic [KEY_LENGTH_W-1:0] l;
    for (int i = 0; i < n; i++) begin
      b = (fill < 0) ? KEY_BYTE_W'($urandom) : KEY_BYTE_W'(fill);
      // length only counts on the first byte; junk elsewhere
      l = (i == 0) ? len : KEY_LENGTH_W'($urandom);
      send_beat(b, l, mark_first && (i == 0), mark_last && (i == n - 1));
    end
  endtask

  // Mostly well-formed keys, with mismatched lengths, abandoned and orphan runs
  task automatic random_key();
    int n;
    int pick;
    n    = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
    pick = $urandom_range(99);
    if (pick < 80)
      send_key(n, KEY_LENGTH_W'(n), 1'b1, 1'b1, -1);
    else if (pick < 87)
      send_key(n, KEY_LENGTH_W'($urandom), 1'b1, 1'b1, -1);
    else if (pick < 93)
      send_key(n, KEY_LENGTH_W'($urandom), 1'b1, 1'b0, -1);
    else
      send_key(n, KEY_LENGTH_W'($urandom), 1'b0, 1'b1, -1);
  endtask

  // Stop offering, wait for every hash due, then let the block settle
  task automatic drain_hashes();
    in_ch.valid <= 1'b0;
    while (sb.hashes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [HASH_W-1:0] s);
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_seed(s);
  endtask

  // Main sequence
  initial begin
    logic [HASH_W-1:0] seed_val;
    int                phase_start;

    calm       = 1'b0;
    hold_req   = 1'b0;
    beats_sent = 0;

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.key_byte   <= '0;
    in_ch.key_length <= '0;
    in_ch.first_byte <= 1'b0;
    in_ch.last_byte  <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed keys on the reset seed
    send_key(1, 16'hffff, 1'b1, 1'b1, 8'hff);  // one-byte key, top length
    send_key(1, 16'h0000, 1'b1, 1'b1, 8'h00);  // zero length in the seed term
    send_key(4, 16'd4, 1'b1, 1'b1, 8'h00);     // exactly one word, no tail
    send_key(3, 16'h8001, 1'b1, 1'b1, -1);     // length disagrees, 3-byte tail
    send_key(2, 16'd2, 1'b0, 1'b1, -1);        // no first marker after a hash
    send_key(2, 16'd9, 1'b1, 1'b0, -1);        // abandoned by a new first byte
    send_key(5, 16'd5, 1'b1, 1'b1, 8'hff);     // word plus 1-byte tail
    send_key(6, 16'd6, 1'b1, 1'b1, -1);        // word plus 2-byte tail

    // Random phases, each on its own seed
    for (int p = 0; p < 6; p++) begin
      drain_hashes();
      case (p)
        0:       seed_val = 32'h0000_0000;
        1:       seed_val = 32'hffff_ffff;
        default: seed_val = $urandom;
      endcase
      write_seed(seed_val);
      calm        = (p == 2);
      phase_start = beats_sent;
      if (p == 3) begin
        // receiver holds off while short keys pile up behind the result slot
        hold_req = 1'b1;
        for (int j = 0; j < 8; j++) begin
          int n;
          n = $urandom_range(1, 3);
          send_key(n, KEY_LENGTH_W'(n), 1'b1, 1'b1, -1);
        end
      end
      while (beats_sent - phase_start < PHASE_BEATS) random_key();
    end
    calm = 1'b0;

    // Wind down
    in_ch.valid <= 1'b0;
    while (sb.hashes_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0)
      $display("tb_murmur2_byte_hasher_top OK");
    else
      $display("tb_murmur2_byte_hasher_top NOT OK");
    $finish;
  end

endmodule

[filelist.f]
hdl/mur2_pkg.sv
hdl/mur2_if.sv
hdl/mur2_mul.sv
hdl/murmur2_byte_hasher_top.sv
tb/tb_murmur2_byte_hasher_top.sv
